### rtl/lamport_request_queue_defines.svh
// ----------------------------------------------------------------------------
// Lamport request queue assertion macros
// Shared property shapes for the concurrent checks in the queue RTL.
// ----------------------------------------------------------------------------
`ifndef LAMPORT_REQUEST_QUEUE_DEFINES_SVH
`define LAMPORT_REQUEST_QUEUE_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define LRQ_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define LRQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/lrq_pkg.sv
// ----------------------------------------------------------------------------
// Lamport request queue package
// Payload structs, operation and status codes, and sequencer states.
// ----------------------------------------------------------------------------
package lrq_pkg;

  localparam logic [1:0] FUNC_REQUEST = 2'd0;
  localparam logic [1:0] FUNC_REPLY   = 2'd1;
  localparam logic [1:0] FUNC_RELEASE = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_NO_MATCH = 2'd2;
  localparam logic [1:0] ST_EMPTY    = 2'd3;

  localparam logic REG_OWN_NODE = 1'b0;

  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] msg_stamp;
    logic        stamp_missing;
    logic [7:0]  msg_node;
    logic [31:0] msg_proc;
    logic [15:0] msg_replies;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] clock_out;
    logic [31:0] out_stamp;
    logic [7:0]  out_node;
    logic [31:0] out_proc;
    logic [15:0] out_replies;
  } rsp_t;

  typedef struct packed {
    logic [31:0] stamp;
    logic [7:0]  node;
    logic [31:0] proc;
    logic [15:0] replies;
  } entry_t;

  typedef struct packed {
    logic [31:0] entry_stamp;
    logic [7:0]  entry_node;
    logic [31:0] key_stamp;
    logic [7:0]  key_node;
    logic [7:0]  own_node;
  } cmp_req_t;

  typedef struct packed {
    logic ins_before;
    logic rep_hit;
    logic rep_exact;
  } cmp_res_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_INSERT,
    S_REPLY_WR,
    S_REL_RD,
    S_REL_OUT
  } state_t;

endpackage

### rtl/lamport_request_queue.sv
// ----------------------------------------------------------------------------
// Lamport request queue
// Logical clock and (stamp, node) ordered lock request queue for mutual
// exclusion, with an APB register for the own node number.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low, and busy stays high
// until its single result has been produced. The result is shown on out_data
// for exactly one cycle with out_valid high and cannot be stalled, so the
// receiver must capture it in that cycle. Queue entries live in a ring buffer
// in a single-port-read memory with registered read data, and the compare
// unit looks at one entry at a time, read in S_SCAN_RD and checked in
// S_SCAN_CHK. A command that fails early ends in S_DISPATCH, an append goes
// from S_DISPATCH to S_INSERT and a release through S_REL_RD to S_REL_OUT.
// A request that is inserted in the middle scans entries, shifts the later
// entries back through S_SHIFT_RD and S_SHIFT_WR and ends in S_INSERT; a
// reply scans and, on a hit, ends in S_REPLY_WR. A new item can be accepted
// in the cycle that shows the previous result.
// ----------------------------------------------------------------------------
module lamport_request_queue #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  lrq_pkg::req_t in_data,
  output logic          out_valid,
  output lrq_pkg::rsp_t out_data,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [2:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);

  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic [7:0]        own_node_r;
  logic              cfg_wr;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  lrq_pkg::entry_t   wr_data;
  logic              rd_en;
  logic [AW-1:0]     rd_addr;
  lrq_pkg::entry_t   rd_data;
  lrq_pkg::cmp_req_t cmp_req;
  lrq_pkg::cmp_res_t cmp_res;

  assign cfg_wr = psel && penable && pwrite && (paddr[2] == lrq_pkg::REG_OWN_NODE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_node_r <= '0;
    end else if (cfg_wr) begin
      own_node_r <= pwdata[7:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == lrq_pkg::REG_OWN_NODE) ? {24'd0, own_node_r} : 32'd0;

  lrq_ram #(
    .DEPTH (QUEUE_DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  lrq_cmp u_cmp (
    .req (cmp_req),
    .res (cmp_res)
  );

  lrq_ctrl #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .AW          (AW),
    .CW          (CW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_data   (in_data),
    .own_node  (own_node_r),
    .busy      (busy),
    .out_valid (out_valid),
    .out_data  (out_data),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .cmp_req   (cmp_req),
    .cmp_res   (cmp_res)
  );

endmodule

### rtl/lrq_ram.sv
// ----------------------------------------------------------------------------
// Lamport request queue entry memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module lrq_ram #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic                 clk,
  input  logic                 wr_en,
  input  logic [AW-1:0]        wr_addr,
  input  lrq_pkg::entry_t      wr_data,
  input  logic                 rd_en,
  input  logic [AW-1:0]        rd_addr,
  output lrq_pkg::entry_t      rd_data
);

  lrq_pkg::entry_t mem_r [DEPTH];
  lrq_pkg::entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### rtl/lrq_cmp.sv
// ----------------------------------------------------------------------------
// Lamport request queue compare unit
// Orders one stored entry against the key of the item in progress and flags own-node reply matches.
// ----------------------------------------------------------------------------
module lrq_cmp (
  input  lrq_pkg::cmp_req_t req,
  output lrq_pkg::cmp_res_t res
);

  logic stamp_lt;
  logic stamp_eq;

  assign stamp_lt = req.key_stamp < req.entry_stamp;
  assign stamp_eq = req.key_stamp == req.entry_stamp;

  assign res.ins_before = stamp_lt || (stamp_eq && (req.key_node < req.entry_node));
  assign res.rep_hit    = (req.entry_node == req.own_node) && !stamp_lt;
  assign res.rep_exact  = stamp_eq;

endmodule

### rtl/lrq_ctrl.sv
// ----------------------------------------------------------------------------
// Lamport request queue sequencer
// Walks the ring-buffered queue one entry at a time for scans and shifts.
// ----------------------------------------------------------------------------
`include "lamport_request_queue_defines.svh"

module lrq_ctrl #(
  parameter int QUEUE_DEPTH = 16,
  parameter int AW          = 4,
  parameter int CW          = 5
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  lrq_pkg::req_t     in_data,
  input  logic [7:0]        own_node,
  output logic              busy,
  output logic              out_valid,
  output lrq_pkg::rsp_t     out_data,
  output logic              wr_en,
  output logic [AW-1:0]     wr_addr,
  output lrq_pkg::entry_t   wr_data,
  output logic              rd_en,
  output logic [AW-1:0]     rd_addr,
  input  lrq_pkg::entry_t   rd_data,
  output lrq_pkg::cmp_req_t cmp_req,
  input  lrq_pkg::cmp_res_t cmp_res
);

  localparam logic [CW-1:0] DEPTH_C  = CW'(QUEUE_DEPTH);
  localparam logic [AW:0]   DEPTH_W  = (AW+1)'(QUEUE_DEPTH);
  localparam logic [AW-1:0] LAST_IDX = AW'(QUEUE_DEPTH - 1);

  lrq_pkg::state_t state_r, state_nxt;
  lrq_pkg::req_t   item_r, item_nxt;
  lrq_pkg::entry_t hit_ent_r, hit_ent_nxt;
  lrq_pkg::rsp_t   res_r, res_nxt;
  logic [31:0]     clock_r, clock_nxt;
  logic [31:0]     stamp_eff_r, stamp_eff_nxt;
  logic [AW-1:0]   head_r, head_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic [CW-1:0]   idx_r, idx_nxt;
  logic [CW-1:0]   pos_r, pos_nxt;
  logic [CW-1:0]   hit_idx_r, hit_idx_nxt;
  logic            found_r, found_nxt;
  logic            out_valid_r, out_valid_nxt;

  logic [31:0]     clk_inc;
  logic [CW-1:0]   idx_inc;
  logic [CW-1:0]   idx_dec;
  logic            fin;
  logic            rel;
  logic [1:0]      fin_status;
  logic            hit_now;

  function automatic logic [AW-1:0] phys(input logic [CW-1:0] li);
    logic [AW:0] sum;
    sum = {1'b0, head_r} + (AW+1)'(li);
    if (sum >= DEPTH_W) begin
      sum = sum - DEPTH_W;
    end
    return sum[AW-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lrq_pkg::S_IDLE;
      clock_r     <= '0;
      head_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clock_r     <= clock_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r      <= item_nxt;
    hit_ent_r   <= hit_ent_nxt;
    res_r       <= res_nxt;
    stamp_eff_r <= stamp_eff_nxt;
    idx_r       <= idx_nxt;
    pos_r       <= pos_nxt;
    hit_idx_r   <= hit_idx_nxt;
    found_r     <= found_nxt;
  end

  assign clk_inc = clock_r + 32'd1;
  assign idx_inc = idx_r + CW'(1);
  assign idx_dec = idx_r - CW'(1);

  always_comb begin
    cmp_req.entry_stamp = rd_data.stamp;
    cmp_req.entry_node  = rd_data.node;
    cmp_req.key_stamp   = stamp_eff_r;
    cmp_req.key_node    = item_r.msg_node;
    cmp_req.own_node    = own_node;
  end

  always_comb begin
    logic [31:0] seff;
    state_nxt     = state_r;
    item_nxt      = item_r;
    hit_ent_nxt   = hit_ent_r;
    res_nxt       = res_r;
    clock_nxt     = clock_r;
    stamp_eff_nxt = stamp_eff_r;
    head_nxt      = head_r;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    pos_nxt       = pos_r;
    hit_idx_nxt   = hit_idx_r;
    found_nxt     = found_r;
    out_valid_nxt = 1'b0;
    wr_en         = 1'b0;
    wr_addr       = phys(idx_r);
    wr_data       = rd_data;
    rd_en         = 1'b0;
    rd_addr       = phys(idx_r);
    fin           = 1'b0;
    rel           = 1'b0;
    fin_status    = lrq_pkg::ST_OK;
    hit_now       = 1'b0;
    seff          = item_r.stamp_missing ? clk_inc : item_r.msg_stamp;

    case (state_r)
      lrq_pkg::S_IDLE: begin
        if (start) begin
          item_nxt  = in_data;
          state_nxt = lrq_pkg::S_DISPATCH;
        end
      end

      lrq_pkg::S_DISPATCH: begin
        idx_nxt   = '0;
        found_nxt = 1'b0;
        case (item_r.func)
          lrq_pkg::FUNC_REQUEST: begin
            clock_nxt = clk_inc;
            if (item_r.msg_node == own_node) begin
              seff    = clk_inc;
              pos_nxt = count_r;
            end else if ((seff >= clk_inc) || (count_r == '0)) begin
              clock_nxt = seff;
              pos_nxt   = count_r;
            end
            stamp_eff_nxt = seff;
            if (count_r == DEPTH_C) begin
              fin        = 1'b1;
              fin_status = lrq_pkg::ST_FULL;
            end else if ((item_r.msg_node == own_node) || (seff >= clk_inc) ||
                         (count_r == '0)) begin
              state_nxt = lrq_pkg::S_INSERT;
            end else begin
              state_nxt = lrq_pkg::S_SCAN_RD;
            end
          end
          lrq_pkg::FUNC_REPLY: begin
            clock_nxt     = clk_inc;
            stamp_eff_nxt = item_r.msg_stamp;
            if (count_r == '0) begin
              fin        = 1'b1;
              fin_status = lrq_pkg::ST_NO_MATCH;
            end else begin
              state_nxt = lrq_pkg::S_SCAN_RD;
            end
          end
          lrq_pkg::FUNC_RELEASE: begin
            clock_nxt = clk_inc;
            if (count_r == '0) begin
              fin        = 1'b1;
              fin_status = lrq_pkg::ST_EMPTY;
            end else begin
              state_nxt = lrq_pkg::S_REL_RD;
            end
          end
          default: begin
            fin = 1'b1;
          end
        endcase
      end

      lrq_pkg::S_SCAN_RD: begin
        rd_en     = 1'b1;
        state_nxt = lrq_pkg::S_SCAN_CHK;
      end

      lrq_pkg::S_SCAN_CHK: begin
        idx_nxt = idx_inc;
        if (item_r.func == lrq_pkg::FUNC_REQUEST) begin
          if (cmp_res.ins_before) begin
            pos_nxt   = idx_r;
            idx_nxt   = count_r;
            state_nxt = lrq_pkg::S_SHIFT_RD;
          end else if (idx_inc == count_r) begin
            pos_nxt   = count_r;
            state_nxt = lrq_pkg::S_INSERT;
          end else begin
            state_nxt = lrq_pkg::S_SCAN_RD;
          end
        end else begin
          hit_now = cmp_res.rep_hit;
          if (hit_now) begin
            found_nxt   = 1'b1;
            hit_idx_nxt = idx_r;
            hit_ent_nxt = rd_data;
          end
          if (hit_now && cmp_res.rep_exact) begin
            state_nxt = lrq_pkg::S_REPLY_WR;
          end else if (idx_inc == count_r) begin
            if (found_nxt) begin
              state_nxt = lrq_pkg::S_REPLY_WR;
            end else begin
              fin        = 1'b1;
              fin_status = lrq_pkg::ST_NO_MATCH;
            end
          end else begin
            state_nxt = lrq_pkg::S_SCAN_RD;
          end
        end
      end

      lrq_pkg::S_SHIFT_RD: begin
        rd_en     = 1'b1;
        rd_addr   = phys(idx_dec);
        state_nxt = lrq_pkg::S_SHIFT_WR;
      end

      lrq_pkg::S_SHIFT_WR: begin
        wr_en   = 1'b1;
        wr_addr = phys(idx_r);
        wr_data = rd_data;
        idx_nxt = idx_dec;
        if (idx_dec == pos_r) begin
          state_nxt = lrq_pkg::S_INSERT;
        end else begin
          state_nxt = lrq_pkg::S_SHIFT_RD;
        end
      end

      lrq_pkg::S_INSERT: begin
        wr_en           = 1'b1;
        wr_addr         = phys(pos_r);
        wr_data.stamp   = stamp_eff_r;
        wr_data.node    = item_r.msg_node;
        wr_data.proc    = item_r.msg_proc;
        wr_data.replies = item_r.msg_replies;
        count_nxt       = count_r + CW'(1);
        fin             = 1'b1;
      end

      lrq_pkg::S_REPLY_WR: begin
        wr_en           = 1'b1;
        wr_addr         = phys(hit_idx_r);
        wr_data         = hit_ent_r;
        wr_data.replies = hit_ent_r.replies + 16'd1;
        fin             = 1'b1;
      end

      lrq_pkg::S_REL_RD: begin
        rd_en     = 1'b1;
        rd_addr   = head_r;
        state_nxt = lrq_pkg::S_REL_OUT;
      end

      lrq_pkg::S_REL_OUT: begin
        head_nxt  = (head_r == LAST_IDX) ? '0 : head_r + AW'(1);
        count_nxt = count_r - CW'(1);
        fin       = 1'b1;
        rel       = 1'b1;
      end

      default: begin
        state_nxt = lrq_pkg::S_IDLE;
      end
    endcase

    if (fin) begin
      state_nxt         = lrq_pkg::S_IDLE;
      out_valid_nxt     = 1'b1;
      res_nxt.status    = fin_status;
      res_nxt.clock_out = clock_nxt;
      res_nxt.out_stamp   = rel ? clock_nxt : 32'd0;
      res_nxt.out_node    = rel ? rd_data.node : 8'd0;
      res_nxt.out_proc    = rel ? rd_data.proc : 32'd0;
      res_nxt.out_replies = rel ? rd_data.replies : 16'd0;
    end
  end

  assign busy      = state_r != lrq_pkg::S_IDLE;
  assign out_valid = out_valid_r;
  assign out_data  = res_r;

  `LRQ_ASSERT_NOW(a_count_bound, 1'b1, count_r <= DEPTH_C, "Queue count exceeds depth.")
  `LRQ_ASSERT_NEXT(a_strobe_single, out_valid_r, !out_valid_r, "Result strobe held too long.")
  `LRQ_ASSERT_NOW(a_strobe_idle, out_valid_r, state_r == lrq_pkg::S_IDLE, "Result shown while busy.")
  `LRQ_ASSERT_NOW(a_release_nonempty, state_r == lrq_pkg::S_REL_OUT, count_r != '0, "Release dequeues from an empty queue.")

endmodule
